FILE: design/lpht_pkg.sv
// shared constants, types and helpers for the linear probing hash table
`timescale 1ns / 1ps
`default_nettype none
package lpht_pkg;

  localparam int SLOTS      = 26;
  localparam int SLOT_W     = 5;
  localparam int WORD_CHARS = 8;
  localparam int WORD_W     = 64;
  localparam int LETTER_W   = 7;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int STATE_W    = 2;

  // only the low WORD_CHARS bytes of a word take part
  localparam logic [WORD_W-1:0] WORD_MASK = {WORD_W{1'b1}} >> (WORD_W - 8 * WORD_CHARS);

  // home slot offset: (letter - 97) mod SLOTS == (letter mod SLOTS + HOME_ADD) mod SLOTS
  localparam int HOME_ADD = SLOTS - (97 % SLOTS);

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] STS_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_REMOVED  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] STS_READ     = 3'd5;

  // slot state codes
  localparam logic [STATE_W-1:0] SLOT_NEVER = 2'd0;
  localparam logic [STATE_W-1:0] SLOT_OCC   = 2'd1;
  localparam logic [STATE_W-1:0] SLOT_TOMB  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic start;   // capture the accepted item
    logic check;   // probe data for pos is on the ram output
    logic commit;  // update the table and load the result register
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic done;    // the probed slot resolves the command
  } sts_t;

  function automatic logic [SLOT_W-1:0] home_slot(input logic [LETTER_W-1:0] letter);
    logic [LETTER_W-1:0] v;
    logic [SLOT_W:0]     s;
    v = letter;
    for (int i = 0; i < 4; i++) begin
      if (v >= LETTER_W'(SLOTS)) begin
        v = v - LETTER_W'(SLOTS);
      end
    end
    s = (SLOT_W + 1)'(v) + (SLOT_W + 1)'(HOME_ADD);
    if (s >= (SLOT_W + 1)'(SLOTS)) begin
      s = s - (SLOT_W + 1)'(SLOTS);
    end
    return s[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: design/lpht_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module lpht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 26
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: design/lpht_dp.sv
// datapath: item capture, probe position, slot state flops, word ram, result register
`timescale 1ns / 1ps
`default_nettype none
module lpht_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lpht_pkg::ctl_t                    ctl,
  output lpht_pkg::sts_t                         sts,
  input  wire logic [lpht_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [lpht_pkg::LETTER_W-1:0]     in_bucket_letter,
  input  wire logic [lpht_pkg::WORD_W-1:0]       in_word,
  input  wire logic [lpht_pkg::SLOT_W-1:0]       in_read_slot,
  output logic      [lpht_pkg::STATUS_W-1:0]     out_status,
  output logic      [lpht_pkg::SLOT_W-1:0]       out_slot,
  output logic      [lpht_pkg::STATE_W-1:0]      out_slot_state,
  output logic      [lpht_pkg::WORD_W-1:0]       out_slot_word
);

  logic [lpht_pkg::CMD_W-1:0]    cmd_r;
  logic [lpht_pkg::WORD_W-1:0]   word_r;
  logic [lpht_pkg::SLOT_W-1:0]   rs_r;
  logic [lpht_pkg::SLOT_W-1:0]   pos_r;
  logic [lpht_pkg::SLOT_W-1:0]   cnt_r;
  logic [lpht_pkg::STATE_W-1:0]  st_r [lpht_pkg::SLOTS];

  logic [lpht_pkg::STATUS_W-1:0] res_status_r;
  logic [lpht_pkg::SLOT_W-1:0]   res_slot_r;
  logic [lpht_pkg::STATE_W-1:0]  res_state_r;
  logic [lpht_pkg::WORD_W-1:0]   res_word_r;

  logic [lpht_pkg::SLOT_W-1:0]   pos_inc;
  logic [lpht_pkg::SLOT_W-1:0]   start_pos;
  logic [lpht_pkg::SLOT_W-1:0]   raddr;
  logic [lpht_pkg::WORD_W-1:0]   rdata;
  logic [lpht_pkg::STATE_W-1:0]  cur_st;
  logic                          is_occ;
  logic                          is_never;
  logic                          match;
  logic                          wrap;
  logic                          rs_ok;
  logic                          done;
  logic                          advance;
  logic                          ins_store;
  logic                          del_hit;

  logic [lpht_pkg::STATUS_W-1:0] res_status;
  logic [lpht_pkg::SLOT_W-1:0]   res_slot;
  logic [lpht_pkg::STATE_W-1:0]  res_state;
  logic [lpht_pkg::WORD_W-1:0]   res_word;

  assign pos_inc = (pos_r == lpht_pkg::SLOT_W'(lpht_pkg::SLOTS - 1)) ? '0
                 : pos_r + lpht_pkg::SLOT_W'(1);

  // a read of a slot beyond the table probes slot zero and reports never used
  assign start_pos = (in_cmd == lpht_pkg::CMD_READ)
                   ? ((in_read_slot < lpht_pkg::SLOT_W'(lpht_pkg::SLOTS)) ? in_read_slot : '0)
                   : lpht_pkg::home_slot(in_bucket_letter);

  assign cur_st   = st_r[pos_r];
  assign is_occ   = (cur_st == lpht_pkg::SLOT_OCC);
  assign is_never = (cur_st == lpht_pkg::SLOT_NEVER);
  assign match    = is_occ && (rdata == word_r);
  assign wrap     = (cnt_r == lpht_pkg::SLOT_W'(lpht_pkg::SLOTS - 1));
  assign rs_ok    = (rs_r < lpht_pkg::SLOT_W'(lpht_pkg::SLOTS));

  always_comb begin
    done       = 1'b1;
    ins_store  = 1'b0;
    del_hit    = 1'b0;
    res_status = lpht_pkg::STS_READ;
    res_slot   = '0;
    res_state  = lpht_pkg::SLOT_NEVER;
    res_word   = '0;
    case (cmd_r)
      lpht_pkg::CMD_INSERT: begin
        done = !is_occ || match || wrap;
        if (!is_occ) begin
          ins_store  = 1'b1;
          res_status = lpht_pkg::STS_INSERTED;
          res_slot   = pos_r;
          res_state  = lpht_pkg::SLOT_OCC;
          res_word   = word_r;
        end else if (match) begin
          res_status = lpht_pkg::STS_PRESENT;
          res_slot   = pos_r;
          res_state  = lpht_pkg::SLOT_OCC;
          res_word   = word_r;
        end else begin
          res_status = lpht_pkg::STS_FULL;
        end
      end
      lpht_pkg::CMD_DELETE: begin
        done = match || is_never || wrap;
        if (match) begin
          del_hit    = 1'b1;
          res_status = lpht_pkg::STS_REMOVED;
          res_slot   = pos_r;
          res_state  = lpht_pkg::SLOT_TOMB;
        end else begin
          res_status = lpht_pkg::STS_NOTFOUND;
        end
      end
      default: begin
        res_status = lpht_pkg::STS_READ;
        res_slot   = rs_r;
        res_state  = rs_ok ? cur_st : lpht_pkg::SLOT_NEVER;
        res_word   = (rs_ok && is_occ) ? rdata : '0;
      end
    endcase
  end

  assign advance  = ctl.check && !done;
  assign raddr    = advance ? pos_inc : pos_r;
  assign sts.done = done;

  lpht_ram #(
    .WIDTH (lpht_pkg::WORD_W),
    .DEPTH (lpht_pkg::SLOTS)
  ) u_word_ram (
    .clk   (clk),
    .we    (ctl.commit && ins_store),
    .waddr (pos_r),
    .wdata (word_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '0;
      for (int i = 0; i < lpht_pkg::SLOTS; i++) begin
        st_r[i] <= lpht_pkg::SLOT_NEVER;
      end
    end else begin
      if (ctl.start) begin
        pos_r <= start_pos;
        cnt_r <= '0;
      end else if (advance) begin
        pos_r <= pos_inc;
        cnt_r <= cnt_r + lpht_pkg::SLOT_W'(1);
      end
      if (ctl.commit && ins_store) begin
        st_r[pos_r] <= lpht_pkg::SLOT_OCC;
      end else if (ctl.commit && del_hit) begin
        st_r[pos_r] <= lpht_pkg::SLOT_TOMB;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cmd_r  <= in_cmd;
      word_r <= in_word & lpht_pkg::WORD_MASK;
      rs_r   <= in_read_slot;
    end
    if (ctl.commit) begin
      res_status_r <= res_status;
      res_slot_r   <= res_slot;
      res_state_r  <= res_state;
      res_word_r   <= res_word;
    end
  end

  assign out_status     = res_status_r;
  assign out_slot       = res_slot_r;
  assign out_slot_state = res_state_r;
  assign out_slot_word  = res_word_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < lpht_pkg::SLOT_W'(lpht_pkg::SLOTS))
    else $error("probe position left the table");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < lpht_pkg::SLOT_W'(lpht_pkg::SLOTS))
    else $error("probe count ran past a full wrap");

  a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> (done && !advance))
    else $error("commit on an unresolved probe");

endmodule
`default_nettype wire

FILE: design/lpht_ctrl.sv
// controller: accept, fetch, probe loop and result handshake
`timescale 1ns / 1ps
`default_nettype none
module lpht_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [lpht_pkg::CMD_W-1:0]  in_cmd,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output lpht_pkg::ctl_t                   ctl,
  input  wire lpht_pkg::sts_t              sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  logic   out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl.start     = 1'b0;
    ctl.check     = 1'b0;
    ctl.commit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // the unused command code is taken and dropped
        if (in_acc && (in_cmd == lpht_pkg::CMD_INSERT || in_cmd == lpht_pkg::CMD_DELETE ||
                       in_cmd == lpht_pkg::CMD_READ)) begin
          ctl.start = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        ctl.check = 1'b1;
        if (sts.done && out_free) begin
          ctl.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented after commit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> out_free)
    else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

FILE: design/linear_probe_hash_table.sv
// top level of the 26-slot linear probing hash table with tombstones
//
// input channel: in_valid / in_stall carry one command item (in_cmd, in_bucket_letter,
//   in_word, in_read_slot); an item is taken at an edge with in_valid high and in_stall low
// commands: insert probes from the home slot (letter - 97, mod 26) to the first free or
//   tombstone slot, or to a slot already holding the word; delete probes to the matching
//   word and leaves a tombstone, stopping at a never-used slot; read reports one slot
// result channel: out_valid / out_stall carry one result item per command (none for the
//   unused command code), held in an output register until taken
// probing: a fetch state reads the home slot, then one word ram read per probed slot, with
//   1 to 26 slots probed per item (1 for read)
// in_stall is high from accept until the result is loaded into the output register; the
//   next item is taken while that result still waits on out_stall
// a resolved probe waits in place while the output register is full and stalled
// reset clears every slot to never used at once; words are held in ram with no reset
// a probe that wraps all 26 slots reports table full (insert) or not found (delete)
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_table (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [lpht_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [lpht_pkg::LETTER_W-1:0]     in_bucket_letter,
  input  wire logic [lpht_pkg::WORD_W-1:0]       in_word,
  input  wire logic [lpht_pkg::SLOT_W-1:0]       in_read_slot,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [lpht_pkg::STATUS_W-1:0]     out_status,
  output logic      [lpht_pkg::SLOT_W-1:0]       out_slot,
  output logic      [lpht_pkg::STATE_W-1:0]      out_slot_state,
  output logic      [lpht_pkg::WORD_W-1:0]       out_slot_word
);

  // command and status between controller and datapath
  lpht_pkg::ctl_t ctl;
  lpht_pkg::sts_t sts;

  // sequencing: accept, fetch, probe loop, result handshake
  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  // slot states, word ram, probe position and result register
  lpht_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_cmd           (in_cmd),
    .in_bucket_letter (in_bucket_letter),
    .in_word          (in_word),
    .in_read_slot     (in_read_slot),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_slot_state   (out_slot_state),
    .out_slot_word    (out_slot_word)
  );

endmodule
`default_nettype wire
